/* sv/vir_pkg.sv */
// shared constants and types for the voxel interior removal core
// no dependencies; imported by the core
package vir_pkg;

  localparam int unsigned VOXEL_W     = 8;
  localparam int unsigned LAYER_CNT_W = 9;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;

  typedef enum logic [0:0] {
    OP_VOXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  // register index, taken from paddr[2]
  typedef enum logic [0:0] {
    REG_LAYER_COUNT = 1'b0,
    REG_UNUSED      = 1'b1
  } reg_idx_e;

endpackage

/* sv/vir_ram.sv */
// generic single-write, single-read ram with registered read data
// read-before-write on a shared address; no dependencies
module vir_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 239,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/voxel_interior_removal_core.sv */
// voxel interior removal core: streams a chunk layer by layer, clears interior voxels
// depends on vir_pkg and two vir_ram delay memories
// one beat per cycle in and out unless m_axis_tready stalls; a result enters the output
// register as its beat leaves the input register, and belongs to the voxel one layer earlier
// the window is two delay rams of LAYER_SIDE^2-LAYER_SIDE-1 entries plus a register line
// reset clears control state and sets layer_count to 1; ram contents stay undefined
module voxel_interior_removal_core #(
  parameter int unsigned MAX_LAYERS = 256,
  parameter int unsigned LAYER_SIDE = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tdata: voxel_in[7:0]
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [vir_pkg::VOXEL_W-1:0]       s_axis_tdata,
  // tuser: op[0]
  input  logic [0:0]                        s_axis_tuser,
  // tdata: voxel_out[7:0]
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [vir_pkg::VOXEL_W-1:0]       m_axis_tdata,
  // tuser: removed[0]
  output logic [0:0]                        m_axis_tuser,
  output logic                              m_axis_tlast,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [vir_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [vir_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [vir_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  import vir_pkg::*;

  localparam int unsigned S  = LAYER_SIDE;
  localparam int unsigned N  = S * S;
  localparam int unsigned D  = N - S - 1;
  localparam int unsigned AW = $clog2(D);
  localparam int unsigned XW = $clog2(S);
  localparam int unsigned OW = $clog2(N);
  localparam int unsigned DW = $clog2(N + 1);
  localparam int unsigned ZW = $clog2(MAX_LAYERS + 1);
  localparam int unsigned EW = (ZW > LAYER_CNT_W) ? ZW : LAYER_CNT_W;

  // configuration
  logic [LAYER_CNT_W-1:0] layer_cnt_q;
  logic                   cfg_wr;
  logic [EW-1:0]          lc_ext;
  logic [ZW-1:0]          eff_layers;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (reg_idx_e'(paddr[2]) == REG_LAYER_COUNT);
  assign prdata = (reg_idx_e'(paddr[2]) == REG_LAYER_COUNT) ?
                  APB_DATA_W'(layer_cnt_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_cnt_q <= LAYER_CNT_W'(1);
    end else if (cfg_wr) begin
      layer_cnt_q <= pwdata[LAYER_CNT_W-1:0];
    end
  end

  assign lc_ext = EW'(layer_cnt_q);
  always_comb begin
    if (lc_ext == '0) begin
      eff_layers = ZW'(1);
    end else if (lc_ext > EW'(MAX_LAYERS)) begin
      eff_layers = ZW'(MAX_LAYERS);
    end else begin
      eff_layers = lc_ext[ZW-1:0];
    end
  end

  // input register
  logic               in_valid_q;
  op_e                in_op_q;
  logic [VOXEL_W-1:0] in_data_q;
  logic               out_valid_q;
  logic               out_free;
  logic               proc;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || out_free;
  assign proc          = in_valid_q && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q   <= op_e'(s_axis_tuser[0]);
      in_data_q <= s_axis_tdata;
    end
  end

  // position of the newest accepted voxel and drain progress
  logic [XW-1:0] x_q, y_q;
  logic [OW-1:0] off_q;
  logic [ZW-1:0] z_q;
  logic [DW-1:0] drn_q;
  logic [OW:0]   drn_pos;
  logic          is_vox, is_drn, emit_v, shift;

  assign drn_pos = (OW + 1)'(off_q) + (OW + 1)'(drn_q);
  assign is_vox  = (in_op_q == OP_VOXEL) && (z_q < eff_layers);
  assign is_drn  = (in_op_q == OP_DRAIN) && (z_q == eff_layers) && (drn_pos < (OW + 1)'(N));
  assign emit_v  = is_vox && (z_q != '0);
  assign shift   = proc && (is_vox || is_drn);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q   <= '0;
      y_q   <= '0;
      off_q <= '0;
      z_q   <= '0;
      drn_q <= '0;
    end else if (proc && is_vox) begin
      drn_q <= '0;
      off_q <= (off_q == OW'(N - 1)) ? '0 : off_q + OW'(1);
      if (x_q == XW'(S - 1)) begin
        x_q <= '0;
        if (y_q == XW'(S - 1)) begin
          y_q <= '0;
          z_q <= z_q + ZW'(1);
        end else begin
          y_q <= y_q + XW'(1);
        end
      end else begin
        x_q <= x_q + XW'(1);
      end
    end else if (proc && is_drn) begin
      drn_q <= drn_q + DW'(1);
    end
  end

  // window: ram a, register line, ram b
  logic [AW-1:0]      ptr_q;
  logic [VOXEL_W-1:0] ra_rdata, rb_rdata;
  logic [VOXEL_W-1:0] line_q [2*S];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else if (shift) begin
      ptr_q <= (ptr_q == AW'(D - 1)) ? '0 : ptr_q + AW'(1);
    end
  end

  vir_ram #(
    .WIDTH (VOXEL_W),
    .DEPTH (D)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (shift),
    .waddr_i (ptr_q),
    .wdata_i (in_data_q),
    .re_i    (shift),
    .raddr_i (ptr_q),
    .rdata_o (ra_rdata)
  );

  vir_ram #(
    .WIDTH (VOXEL_W),
    .DEPTH (D)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (shift),
    .waddr_i (ptr_q),
    .wdata_i (line_q[2*S-1]),
    .re_i    (shift),
    .raddr_i (ptr_q),
    .rdata_o (rb_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (shift) begin
      line_q[0] <= ra_rdata;
      for (int k = 1; k < 2 * S; k++) begin
        line_q[k] <= line_q[k-1];
      end
    end
  end

  // neighborhood test on the voxel one layer back
  logic [VOXEL_W-1:0] center;
  logic               x_ok, y_ok, z_ok, inner;

  assign center = line_q[S-1];
  assign x_ok   = (x_q != '0) && (x_q <= XW'(S - 2));
  assign y_ok   = (y_q != '0) && (y_q <= XW'(S - 2));
  assign z_ok   = (z_q >= ZW'(2)) && (((ZW + 1)'(z_q) + (ZW + 1)'(1)) <= (ZW + 1)'(eff_layers));
  assign inner  = x_ok && y_ok && z_ok && (center != '0)
                  && (line_q[S-2] != '0) && (line_q[S] != '0)
                  && (line_q[2*S-1] != '0) && (ra_rdata != '0)
                  && (rb_rdata != '0) && (in_data_q != '0);

  // output register
  logic [VOXEL_W-1:0] out_data_q;
  logic               out_removed_q;
  logic               out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= proc && (emit_v || is_drn);
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      if (is_drn) begin
        out_data_q    <= center;
        out_removed_q <= 1'b0;
        out_last_q    <= (drn_pos == (OW + 1)'(N - 1));
      end else begin
        out_data_q    <= inner ? '0 : center;
        out_removed_q <= inner;
        out_last_q    <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_removed_q;
  assign m_axis_tlast    = out_last_q;

  // checks
  a_removed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("removed beat carries nonzero data");

  a_last_not_removed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> !m_axis_tuser[0])
    else $error("last beat marked removed");

  a_drain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drn_q <= DW'(N))
    else $error("drain count past one layer");

  a_drain_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift && (in_op_q == OP_DRAIN) |=> out_valid_q)
    else $error("drain beat produced no result");

endmodule
